// ===== rtl/bcz_pkg.sv =====
// Shared types, constants and helpers of the bilinear centre zoom unit.
// Used by every module under rtl/ but bcz_ram; depends on nothing.
package bcz_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_DIM    = 2;

  // Field and register widths
  localparam int PIX_W      = 16;
  localparam int DIM_CFG_W  = 9;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 12;
  localparam int ONE_Q      = 1 << FRAC_BITS;

  // Register reset values
  localparam logic [DIM_CFG_W-1:0] RST_WIDTH  = DIM_CFG_W'(128);
  localparam logic [DIM_CFG_W-1:0] RST_HEIGHT = DIM_CFG_W'(128);
  localparam logic [SCALE_W-1:0]   RST_INV_X  = SCALE_W'(ONE_Q);
  localparam logic [SCALE_W-1:0]   RST_INV_Y  = SCALE_W'(ONE_Q);

  // Derived widths
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = ADDR_W + 1;
  localparam int DIM_W  = (W_W > H_W) ? W_W : H_W;
  localparam int DIFF_W = DIM_W + 1;
  localparam int SX_W   = DIFF_W + SCALE_W + 2;
  localparam int INT_W  = SX_W - FRAC_BITS;
  localparam int WGT_W  = 2 * FRAC_BITS + 1;
  localparam int PROD_W = WGT_W + 1 + PIX_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RES_W  = ACC_W - 2 * FRAC_BITS;

  // Function codes carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_INV_X  = 2'd2,
    REG_INV_Y  = 2'd3
  } cfg_reg_t;

  // Neighbour order: top left, top right, bottom left, bottom right
  typedef enum logic [1:0] {
    TAP_00 = 2'd0,
    TAP_01 = 2'd1,
    TAP_10 = 2'd2,
    TAP_11 = 2'd3
  } tap_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_FLR  = 3'd2,
    S_ADR  = 3'd3,
    S_RD   = 3'd4,
    S_DRN1 = 3'd5,
    S_DRN2 = 3'd6,
    S_FIN  = 3'd7
  } state_t;

  typedef struct packed {
    logic [W_W-1:0]     w;
    logic [H_W-1:0]     h;
    logic [SCALE_W-1:0] inv_x;
    logic [SCALE_W-1:0] inv_y;
  } dims_t;

  typedef struct packed {
    logic [COL_W-1:0]     x0;
    logic [ROW_W-1:0]     y0;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                 in_frame;
  } coord_t;

  typedef struct packed {
    logic clear;
    logic issue;
    tap_t tap;
  } blend_ctl_t;

  // Clamp a configured frame dimension into MIN_DIM..maxv
  function automatic logic [31:0] clamp_dim(input logic [DIM_CFG_W-1:0] v,
                                            input logic [31:0] maxv);
    logic [31:0] val;
    val = 32'(v);
    if (val < 32'(MIN_DIM)) begin
      val = 32'(MIN_DIM);
    end else if (val > maxv) begin
      val = maxv;
    end
    return val;
  endfunction

endpackage

// ===== rtl/bcz_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Standalone; holds the frame store of the zoom unit.
module bcz_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  // Write or read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ===== rtl/bcz_coord.sv =====
// Source coordinate pipeline: centre-relative scaling, floor and bounds
// check, then the top-left neighbour address. Depends on bcz_pkg.
module bcz_coord (
  input  logic                        clk,
  input  bcz_pkg::dims_t              dims,
  input  logic [bcz_pkg::ROW_W-1:0]   row,
  input  logic [bcz_pkg::COL_W-1:0]   col,
  output bcz_pkg::coord_t             crd,
  output logic [bcz_pkg::ADDR_W-1:0]  base
);

  logic [bcz_pkg::W_W-1:0]            hw;
  logic [bcz_pkg::H_W-1:0]            hh;
  logic signed [bcz_pkg::DIFF_W-1:0]  dx;
  logic signed [bcz_pkg::DIFF_W-1:0]  dy;
  logic signed [bcz_pkg::SCALE_W:0]   inv_xs;
  logic signed [bcz_pkg::SCALE_W:0]   inv_ys;
  logic signed [bcz_pkg::SX_W-1:0]    hwq;
  logic signed [bcz_pkg::SX_W-1:0]    hhq;
  logic signed [bcz_pkg::SX_W-1:0]    sx_nxt;
  logic signed [bcz_pkg::SX_W-1:0]    sy_nxt;
  logic signed [bcz_pkg::SX_W-1:0]    sx_r;
  logic signed [bcz_pkg::SX_W-1:0]    sy_r;
  logic [bcz_pkg::INT_W-1:0]          x0i;
  logic [bcz_pkg::INT_W-1:0]          y0i;
  logic [bcz_pkg::INT_W:0]            x0p2;
  logic [bcz_pkg::INT_W:0]            y0p2;
  logic                               in_x;
  logic                               in_y;
  bcz_pkg::coord_t                    crd_nxt;
  bcz_pkg::coord_t                    crd_r;
  logic [bcz_pkg::SIZE_W-1:0]         base_full;
  logic [bcz_pkg::ADDR_W-1:0]         base_nxt;
  logic [bcz_pkg::ADDR_W-1:0]         base_r;

  // Scale the offsets from the integer centre, in Q.12
  always_comb begin
    hw     = dims.w >> 1;
    hh     = dims.h >> 1;
    dx     = $signed(bcz_pkg::DIFF_W'(col)) - $signed(bcz_pkg::DIFF_W'(hw));
    dy     = $signed(bcz_pkg::DIFF_W'(row)) - $signed(bcz_pkg::DIFF_W'(hh));
    inv_xs = $signed({1'b0, dims.inv_x});
    inv_ys = $signed({1'b0, dims.inv_y});
    hwq    = $signed(bcz_pkg::SX_W'(hw) << bcz_pkg::FRAC_BITS);
    hhq    = $signed(bcz_pkg::SX_W'(hh) << bcz_pkg::FRAC_BITS);
    sx_nxt = dx * inv_xs + hwq;
    sy_nxt = dy * inv_ys + hhq;
  end

  // Floor by dropping the fraction; flag whether the 2x2 window lies inside the frame
  always_comb begin
    x0i              = sx_r[bcz_pkg::SX_W-1:bcz_pkg::FRAC_BITS];
    y0i              = sy_r[bcz_pkg::SX_W-1:bcz_pkg::FRAC_BITS];
    x0p2             = {1'b0, x0i} + (bcz_pkg::INT_W + 1)'(2);
    y0p2             = {1'b0, y0i} + (bcz_pkg::INT_W + 1)'(2);
    in_x             = !x0i[bcz_pkg::INT_W-1] &&
                       (x0p2 <= (bcz_pkg::INT_W + 1)'(dims.w));
    in_y             = !y0i[bcz_pkg::INT_W-1] &&
                       (y0p2 <= (bcz_pkg::INT_W + 1)'(dims.h));
    crd_nxt.x0       = x0i[bcz_pkg::COL_W-1:0];
    crd_nxt.y0       = y0i[bcz_pkg::ROW_W-1:0];
    crd_nxt.fx       = sx_r[bcz_pkg::FRAC_BITS-1:0];
    crd_nxt.fy       = sy_r[bcz_pkg::FRAC_BITS-1:0];
    crd_nxt.in_frame = in_x && in_y;
  end

  // Raster address of the top-left neighbour
  always_comb begin
    base_full = bcz_pkg::SIZE_W'(crd_r.y0) * bcz_pkg::SIZE_W'(dims.w) +
                bcz_pkg::SIZE_W'(crd_r.x0);
    base_nxt  = base_full[bcz_pkg::ADDR_W-1:0];
  end

  // Advance the pipeline every cycle; inputs hold steady during an item
  always_ff @(posedge clk) begin
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    crd_r  <= crd_nxt;
    base_r <= base_nxt;
  end

  assign crd  = crd_r;
  assign base = base_r;

endmodule

// ===== rtl/bcz_blend.sv =====
// Bilinear blend: weight, multiply and accumulate one neighbour a step,
// then round half up and saturate. Depends on bcz_pkg.
module bcz_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bcz_pkg::blend_ctl_t                ctl,
  input  logic [bcz_pkg::FRAC_BITS-1:0]      fx,
  input  logic [bcz_pkg::FRAC_BITS-1:0]      fy,
  input  logic signed [bcz_pkg::PIX_W-1:0]   rdata,
  output logic signed [bcz_pkg::PIX_W-1:0]   result
);

  localparam int OP_W = bcz_pkg::FRAC_BITS + 1;
  localparam logic signed [bcz_pkg::RES_W-1:0] SAT_HI =
    bcz_pkg::RES_W'((1 << (bcz_pkg::PIX_W - 1)) - 1);
  localparam logic signed [bcz_pkg::RES_W-1:0] SAT_LO =
    bcz_pkg::RES_W'(-(1 << (bcz_pkg::PIX_W - 1)));
  localparam logic signed [bcz_pkg::ACC_W-1:0] ROUND_HALF =
    bcz_pkg::ACC_W'(1) << (2 * bcz_pkg::FRAC_BITS - 1);

  logic [OP_W-1:0]                    gx;
  logic [OP_W-1:0]                    gy;
  logic [OP_W-1:0]                    opa;
  logic [OP_W-1:0]                    opb;
  logic [2*OP_W-1:0]                  wgt_full;
  logic [bcz_pkg::WGT_W-1:0]          wgt_r;
  logic                               v1_r;
  logic                               v2_r;
  logic signed [bcz_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [bcz_pkg::PROD_W-1:0]  prod_r;
  logic signed [bcz_pkg::ACC_W-1:0]   acc_nxt;
  logic signed [bcz_pkg::ACC_W-1:0]   acc_r;
  logic signed [bcz_pkg::ACC_W-1:0]   rnd;
  logic signed [bcz_pkg::RES_W-1:0]   q;

  // Pick the weight factors of the current neighbour
  always_comb begin
    gx  = OP_W'(bcz_pkg::ONE_Q) - OP_W'(fx);
    gy  = OP_W'(bcz_pkg::ONE_Q) - OP_W'(fy);
    opa = gx;
    opb = gy;
    case (ctl.tap)
      bcz_pkg::TAP_00: begin
        opa = gx;
        opb = gy;
      end
      bcz_pkg::TAP_01: begin
        opa = OP_W'(fx);
        opb = gy;
      end
      bcz_pkg::TAP_10: begin
        opa = gx;
        opb = OP_W'(fy);
      end
      bcz_pkg::TAP_11: begin
        opa = OP_W'(fx);
        opb = OP_W'(fy);
      end
      default: begin
        opa = gx;
        opb = gy;
      end
    endcase
    wgt_full = opa * opb;
  end

  // Weight times pixel, then accumulate
  always_comb begin
    prod_nxt = $signed({1'b0, wgt_r}) * rdata;
    acc_nxt  = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + bcz_pkg::ACC_W'(prod_r);
    end
  end

  // Track the read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      wgt_r <= wgt_full[bcz_pkg::WGT_W-1:0];
    end
    if (v1_r) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  // Round half up from Q.24 and saturate to the pixel range
  always_comb begin
    rnd = acc_r + ROUND_HALF;
    q   = rnd[bcz_pkg::ACC_W-1:2*bcz_pkg::FRAC_BITS];
    if (q > SAT_HI) begin
      result = SAT_HI[bcz_pkg::PIX_W-1:0];
    end else if (q < SAT_LO) begin
      result = SAT_LO[bcz_pkg::PIX_W-1:0];
    end else begin
      result = q[bcz_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== rtl/bilinear_center_zoom_unit.sv =====
// Bilinear centre zoom unit: top level with configuration registers,
// the sequencer and the frame store. Depends on bcz_pkg, bcz_ram,
// bcz_coord and bcz_blend.
//
// Input stream: in_tuser selects the function. A load transaction writes
// in_tdata into the frame store at the load pointer, in raster order, and
// gives no result. An emit transaction yields the next output pixel in
// raster order, with out_tlast on the bottom-right pixel of the frame.
// Configuration: cfg_ready is always high; write only while idle.
// Handshake: a load leaves in_tready high. An emit holds in_tready low
// while the sequencer steps through MUL, FLR, ADR, an RD for each of the
// four neighbours, DRN1, DRN2 and FIN when its 2x2 neighbourhood lies
// inside the frame, and through MUL, FLR, ADR and FIN when it does not; no
// transaction is taken until it is back in IDLE. The four neighbour reads
// through the single memory port and the weight, multiply and accumulate
// pipeline behind them set this. out_tvalid is registered and rises once FIN loads the pixel.
// Stall: a finished pixel waits in the output register; loads are still
// taken meanwhile, and a following emit holds its result until it is free.
// Reset: pointers, output counters and registers return to their defaults.
// The frame store is not cleared and must be loaded before emitting.
module bilinear_center_zoom_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [15:0] pixel_value
  input  logic                             in_tuser,   // [0] func
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,  // [15:0] out_pixel
  output logic                             out_tlast,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcz_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  logic [bcz_pkg::DIM_CFG_W-1:0] width_r;
  logic [bcz_pkg::DIM_CFG_W-1:0] height_r;
  logic [bcz_pkg::SCALE_W-1:0]   inv_x_r;
  logic [bcz_pkg::SCALE_W-1:0]   inv_y_r;
  logic [31:0]                   w_full;
  logic [31:0]                   h_full;
  bcz_pkg::dims_t                dims;
  logic [bcz_pkg::SIZE_W-1:0]    size;

  // Sequencer
  bcz_pkg::state_t               state_r;
  bcz_pkg::state_t               state_nxt;
  bcz_pkg::tap_t                 tap_r;
  bcz_pkg::tap_t                 tap_nxt;
  logic                          accept;
  logic                          is_load;
  logic                          is_emit;
  logic                          out_load;

  // Load pointer
  logic [bcz_pkg::ADDR_W-1:0]    lp_r;
  logic [bcz_pkg::ADDR_W-1:0]    lp_nxt;
  logic [bcz_pkg::ADDR_W-1:0]    lp_addr;
  logic [bcz_pkg::SIZE_W-1:0]    lp_inc;

  // Output raster position
  logic [bcz_pkg::ROW_W-1:0]     row_r;
  logic [bcz_pkg::COL_W-1:0]     col_r;
  logic [bcz_pkg::ROW_W-1:0]     row_nxt;
  logic [bcz_pkg::COL_W-1:0]     col_nxt;
  logic [bcz_pkg::ROW_W-1:0]     cur_row;
  logic [bcz_pkg::COL_W-1:0]     cur_col;
  logic [bcz_pkg::W_W-1:0]       col_inc;
  logic [bcz_pkg::H_W-1:0]       row_inc;
  logic                          cur_last;
  logic [bcz_pkg::ROW_W-1:0]     em_row_r;
  logic [bcz_pkg::COL_W-1:0]     em_col_r;
  logic                          em_last_r;

  // Datapath
  bcz_pkg::coord_t               crd;
  logic [bcz_pkg::ADDR_W-1:0]    base;
  logic [bcz_pkg::SIZE_W-1:0]    rd_full;
  logic [bcz_pkg::ADDR_W-1:0]    rd_addr;
  logic                          ram_we;
  logic [bcz_pkg::ADDR_W-1:0]    ram_addr;
  logic [bcz_pkg::PIX_W-1:0]     ram_rdata;
  bcz_pkg::blend_ctl_t           bctl;
  logic signed [bcz_pkg::PIX_W-1:0] blend_res;

  // Output register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [bcz_pkg::PIX_W-1:0]     out_pixel_r;
  logic                          out_last_r;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bcz_pkg::RST_WIDTH;
      height_r <= bcz_pkg::RST_HEIGHT;
      inv_x_r  <= bcz_pkg::RST_INV_X;
      inv_y_r  <= bcz_pkg::RST_INV_Y;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bcz_pkg::cfg_reg_t'(cfg_index))
        bcz_pkg::REG_WIDTH:  width_r  <= cfg_data[bcz_pkg::DIM_CFG_W-1:0];
        bcz_pkg::REG_HEIGHT: height_r <= cfg_data[bcz_pkg::DIM_CFG_W-1:0];
        bcz_pkg::REG_INV_X:  inv_x_r  <= cfg_data[bcz_pkg::SCALE_W-1:0];
        bcz_pkg::REG_INV_Y:  inv_y_r  <= cfg_data[bcz_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size in use
  always_comb begin
    w_full     = bcz_pkg::clamp_dim(width_r, 32'(bcz_pkg::MAX_WIDTH));
    h_full     = bcz_pkg::clamp_dim(height_r, 32'(bcz_pkg::MAX_HEIGHT));
    dims.w     = w_full[bcz_pkg::W_W-1:0];
    dims.h     = h_full[bcz_pkg::H_W-1:0];
    dims.inv_x = inv_x_r;
    dims.inv_y = inv_y_r;
    size       = bcz_pkg::SIZE_W'(dims.w) * bcz_pkg::SIZE_W'(dims.h);
  end

  // Input handshake
  assign in_tready = (state_r == bcz_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_load   = accept && (in_tuser == bcz_pkg::FUNC_LOAD);
  assign is_emit   = accept && (in_tuser == bcz_pkg::FUNC_EMIT);

  // Load pointer: restart when it lies beyond the frame, wrap at its end
  always_comb begin
    lp_addr = ({1'b0, lp_r} >= size) ? '0 : lp_r;
    lp_inc  = {1'b0, lp_addr} + bcz_pkg::SIZE_W'(1);
    lp_nxt  = (lp_inc >= size) ? '0 : lp_inc[bcz_pkg::ADDR_W-1:0];
  end

  // Output raster position: restart outside the frame, wrap at its end
  always_comb begin
    if ((bcz_pkg::H_W'(row_r) >= dims.h) || (bcz_pkg::W_W'(col_r) >= dims.w)) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = row_r;
      cur_col = col_r;
    end
    cur_last = (bcz_pkg::H_W'(cur_row) == dims.h - bcz_pkg::H_W'(1)) &&
               (bcz_pkg::W_W'(cur_col) == dims.w - bcz_pkg::W_W'(1));
    col_inc  = bcz_pkg::W_W'(cur_col) + bcz_pkg::W_W'(1);
    row_inc  = bcz_pkg::H_W'(cur_row) + bcz_pkg::H_W'(1);
    col_nxt  = col_inc[bcz_pkg::COL_W-1:0];
    row_nxt  = cur_row;
    if (col_inc >= dims.w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= dims.h) ? '0 : row_inc[bcz_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r  <= '0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      if (is_load) begin
        lp_r <= lp_nxt;
      end
      if (is_emit) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  // Hold the position of the pixel being worked on
  always_ff @(posedge clk) begin
    if (is_emit) begin
      em_row_r  <= cur_row;
      em_col_r  <= cur_col;
      em_last_r <= cur_last;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcz_pkg::S_IDLE: if (is_emit) state_nxt = bcz_pkg::S_MUL;
      bcz_pkg::S_MUL:  state_nxt = bcz_pkg::S_FLR;
      bcz_pkg::S_FLR:  state_nxt = bcz_pkg::S_ADR;
      bcz_pkg::S_ADR:  state_nxt = crd.in_frame ? bcz_pkg::S_RD : bcz_pkg::S_FIN;
      bcz_pkg::S_RD:   if (tap_r == bcz_pkg::TAP_11) state_nxt = bcz_pkg::S_DRN1;
      bcz_pkg::S_DRN1: state_nxt = bcz_pkg::S_DRN2;
      bcz_pkg::S_DRN2: state_nxt = bcz_pkg::S_FIN;
      bcz_pkg::S_FIN:  if (!out_valid_r || out_tready) state_nxt = bcz_pkg::S_IDLE;
      default:         state_nxt = bcz_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    bctl.clear = 1'b0;
    bctl.issue = 1'b0;
    bctl.tap   = tap_r;
    tap_nxt    = tap_r;
    out_load   = 1'b0;
    unique case (state_r)
      bcz_pkg::S_MUL: bctl.clear = 1'b1;
      bcz_pkg::S_ADR: tap_nxt = bcz_pkg::TAP_00;
      bcz_pkg::S_RD: begin
        bctl.issue = 1'b1;
        tap_nxt    = bcz_pkg::tap_t'(2'(tap_r) + 2'd1);
      end
      bcz_pkg::S_FIN: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcz_pkg::S_IDLE;
      tap_r   <= bcz_pkg::TAP_00;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // Neighbour address for the current read
  always_comb begin
    rd_full = bcz_pkg::SIZE_W'(base);
    case (tap_r)
      bcz_pkg::TAP_00: rd_full = bcz_pkg::SIZE_W'(base);
      bcz_pkg::TAP_01: rd_full = bcz_pkg::SIZE_W'(base) + bcz_pkg::SIZE_W'(1);
      bcz_pkg::TAP_10: rd_full = bcz_pkg::SIZE_W'(base) + bcz_pkg::SIZE_W'(dims.w);
      bcz_pkg::TAP_11: rd_full = bcz_pkg::SIZE_W'(base) + bcz_pkg::SIZE_W'(dims.w) +
                                 bcz_pkg::SIZE_W'(1);
      default:         rd_full = bcz_pkg::SIZE_W'(base);
    endcase
    rd_addr  = rd_full[bcz_pkg::ADDR_W-1:0];
    ram_we   = is_load;
    ram_addr = ram_we ? lp_addr : rd_addr;
  end

  bcz_ram #(
    .DATA_W (bcz_pkg::PIX_W),
    .DEPTH  (bcz_pkg::DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata),
    .rdata (ram_rdata)
  );

  bcz_coord u_coord (
    .clk  (clk),
    .dims (dims),
    .row  (em_row_r),
    .col  (em_col_r),
    .crd  (crd),
    .base (base)
  );

  bcz_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (bctl),
    .fx     (crd.fx),
    .fy     (crd.fy),
    .rdata  ($signed(ram_rdata)),
    .result (blend_res)
  );

  // Output register: load a finished pixel, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= blend_res;
      out_last_r  <= em_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // A result appears only after the sequencer has finished a pixel
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == bcz_pkg::S_FIN))
    else $error("output valid raised outside the finish state");

  // Reads are only issued for neighbourhoods inside the frame
  a_read_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcz_pkg::S_RD) |-> crd.in_frame)
    else $error("frame store read for a pixel outside the frame");

  // Draining starts only after all four neighbours were read
  a_four_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcz_pkg::S_DRN1) |->
      $past(state_r == bcz_pkg::S_RD && tap_r == bcz_pkg::TAP_11))
    else $error("blend drained before the last neighbour read");

  // No load write lands while an emit is in flight
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bcz_pkg::S_IDLE) |-> !ram_we)
    else $error("frame store written during an emit");
`endif

endmodule

// ===== tb/tb_bilinear_center_zoom_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_center_zoom_unit: loads frames, emits zoomed
// pixels and checks every one against a bit-exact software predictor.
// Depends on bcz_pkg and the RTL under rtl/.
module tb_bilinear_center_zoom_unit;

  // Expected output pixel, with its raster position for diagnostics
  typedef struct {
    logic [bcz_pkg::PIX_W-1:0] pixel;
    logic                      last;
    int                        row;
    int                        col;
  } zoom_pixel_t;

  // Tracks loads, registers and the output raster; predicts each emitted pixel
  class zoom_scoreboard;
    shortint                         frame_px [bcz_pkg::DEPTH];
    int                              load_ptr;
    int                              row;
    int                              col;
    logic [bcz_pkg::DIM_CFG_W-1:0]   width_reg;
    logic [bcz_pkg::DIM_CFG_W-1:0]   height_reg;
    logic [bcz_pkg::SCALE_W-1:0]     inv_x;
    logic [bcz_pkg::SCALE_W-1:0]     inv_y;
    zoom_pixel_t                     pending_pixels[$];
    int                              errors;

    function new();
      load_ptr   = 0;
      row        = 0;
      col        = 0;
      width_reg  = 9'd128;
      height_reg = 9'd128;
      inv_x      = 16'd4096;
      inv_y      = 16'd4096;
      errors     = 0;
    endfunction

    function int dim_of(logic [bcz_pkg::DIM_CFG_W-1:0] v, int maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return int'(v);
    endfunction

    function int frame_w();
      return dim_of(width_reg, bcz_pkg::MAX_WIDTH);
    endfunction

    function int frame_h();
      return dim_of(height_reg, bcz_pkg::MAX_HEIGHT);
    endfunction

    function void write_reg(bcz_pkg::cfg_reg_t idx, logic [bcz_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bcz_pkg::REG_WIDTH:  width_reg  = data[bcz_pkg::DIM_CFG_W-1:0];
        bcz_pkg::REG_HEIGHT: height_reg = data[bcz_pkg::DIM_CFG_W-1:0];
        bcz_pkg::REG_INV_X:  inv_x      = data[bcz_pkg::SCALE_W-1:0];
        bcz_pkg::REG_INV_Y:  inv_y      = data[bcz_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Bilinear blend about the integer centre; zero when the 2x2 window leaves the frame
    function logic [bcz_pkg::PIX_W-1:0] interp_pixel(int w, int h, int r, int c);
      longint hw, hh, sx, sy, x0, y0, fx, fy, gx, gy, acc, res;
      hw = w / 2;
      hh = h / 2;
      sx = (longint'(c) - hw) * longint'(inv_x) + hw * bcz_pkg::ONE_Q;
      sy = (longint'(r) - hh) * longint'(inv_y) + hh * bcz_pkg::ONE_Q;
      // arithmetic shift floors negative coordinates
      x0 = sx >>> bcz_pkg::FRAC_BITS;
      y0 = sy >>> bcz_pkg::FRAC_BITS;
      if (x0 < 0 || x0 + 1 > w - 1) return '0;
      if (y0 < 0 || y0 + 1 > h - 1) return '0;
      fx = sx - (x0 <<< bcz_pkg::FRAC_BITS);
      fy = sy - (y0 <<< bcz_pkg::FRAC_BITS);
      gx = bcz_pkg::ONE_Q - fx;
      gy = bcz_pkg::ONE_Q - fy;
      acc = gx * gy * longint'(frame_px[y0 * w + x0])
          + fx * gy * longint'(frame_px[y0 * w + x0 + 1])
          + gx * fy * longint'(frame_px[(y0 + 1) * w + x0])
          + fx * fy * longint'(frame_px[(y0 + 1) * w + x0 + 1]);
      // round half up, then saturate
      res = (acc + (longint'(1) <<< (2 * bcz_pkg::FRAC_BITS - 1)))
            >>> (2 * bcz_pkg::FRAC_BITS);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[bcz_pkg::PIX_W-1:0];
    endfunction

    // Note one accepted input transaction
    function void note_input(logic func, logic [bcz_pkg::PIX_W-1:0] data);
      int w, h, size;
      zoom_pixel_t want;
      w    = frame_w();
      h    = frame_h();
      size = w * h;
      if (func == bcz_pkg::FUNC_LOAD) begin
        if (load_ptr >= size) load_ptr = 0;
        frame_px[load_ptr] = shortint'(data);
        load_ptr++;
        if (load_ptr >= size) load_ptr = 0;
      end else begin
        // restart the raster if a size change left it outside the frame
        if (row >= h || col >= w) begin
          row = 0;
          col = 0;
        end
        want.pixel = interp_pixel(w, h, row, col);
        want.last  = (row == h - 1) && (col == w - 1);
        want.row   = row;
        want.col   = col;
        pending_pixels.push_back(want);
        col++;
        if (col >= w) begin
          col = 0;
          row++;
          if (row >= h) row = 0;
        end
      end
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_result(logic [bcz_pkg::PIX_W-1:0] pixel, logic last_flag);
      zoom_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel, expected none, actual %0d last %b",
                 $time, $signed(pixel), last_flag);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $display("%0t: pixel (%0d,%0d) expected %0d, actual %0d", $time, want.row,
                 want.col, $signed(want.pixel), $signed(pixel));
        errors++;
      end
      if (last_flag !== want.last) begin
        $display("%0t: tlast at (%0d,%0d) expected %b, actual %b", $time, want.row,
                 want.col, want.last, last_flag);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [15:0]                     in_tdata   = '0;
  logic                            in_tuser   = bcz_pkg::FUNC_LOAD;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;
  logic                            out_tlast;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [bcz_pkg::CFG_IDX_W-1:0]   cfg_index  = bcz_pkg::REG_WIDTH;
  logic [bcz_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  zoom_scoreboard sb;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  bilinear_center_zoom_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #6_000_000;
    $display("bilinear_center_zoom_unit verification failed");
    $finish;
  end

  // Monitor every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      sb.write_reg(bcz_pkg::cfg_reg_t'(cfg_index), cfg_data);
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Stall the result stream in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(bcz_pkg::cfg_reg_t idx, logic [bcz_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one input transaction, with an optional idle burst ahead of it
  task automatic send_item(logic func, logic [15:0] pix);
    int gap;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, drain the results and let a trailing load settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'd0;
      3:       return 16'd4096;
      4:       return 16'($urandom_range(1024, 12288));
      5:       return 16'($urandom);
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  // Size registers carry random junk above the 9 bits in use
  function automatic logic [15:0] dim_word(int v);
    return {7'($urandom), 9'(v)};
  endfunction

  initial begin
    int n_phases;
    int wv, hv, n_mixed;
    logic [15:0] sx_reg, sy_reg;
    sb = new();
    n_phases = 5;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: width below the minimum, identity scales from reset, extreme pixels
    write_reg(bcz_pkg::REG_WIDTH, 16'd1);
    write_reg(bcz_pkg::REG_HEIGHT, 16'd2);
    send_item(bcz_pkg::FUNC_LOAD, 16'h7FFF);
    send_item(bcz_pkg::FUNC_LOAD, 16'h8000);
    send_item(bcz_pkg::FUNC_LOAD, 16'hFFFF);
    send_item(bcz_pkg::FUNC_LOAD, 16'h0000);
    repeat (5) send_item(bcz_pkg::FUNC_EMIT, 16'hFFFF);
    wait_idle();

    // Directed: negative source x just below zero, zero inverse scale in y
    write_reg(bcz_pkg::REG_WIDTH, 16'd4);
    write_reg(bcz_pkg::REG_HEIGHT, 16'd3);
    write_reg(bcz_pkg::REG_INV_X, 16'd10240);
    write_reg(bcz_pkg::REG_INV_Y, 16'd0);
    for (int i = 0; i < 12; i++) begin
      send_item(bcz_pkg::FUNC_LOAD,
                (i % 2 == 0) ? 16'h5555 + 16'(i) : 16'hAAAA - 16'(i));
    end
    repeat (4) send_item(bcz_pkg::FUNC_EMIT, 16'h0000);
    wait_idle();

    // Random phases: reconfigure, load a whole frame, then mix loads and emits
    for (int p = 0; p < n_phases; p++) begin
      case (p)
        0: begin
          // widest frame, flattest height, sampling close to the centre
          wv = 300; hv = 0; sx_reg = 16'd1; sy_reg = 16'd1;
        end
        default: begin
          wv = $urandom_range(0, 5);
          hv = $urandom_range(0, 5);
          sx_reg = pick_scale();
          sy_reg = pick_scale();
        end
      endcase
      // quiet stretches, and no idling at all in the last part
      if (p >= n_phases - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      write_reg(bcz_pkg::REG_WIDTH, dim_word(wv));
      write_reg(bcz_pkg::REG_HEIGHT, dim_word(hv));
      write_reg(bcz_pkg::REG_INV_X, sx_reg);
      write_reg(bcz_pkg::REG_INV_Y, sy_reg);
      repeat (sb.frame_w() * sb.frame_h()) send_item(bcz_pkg::FUNC_LOAD, rand_pixel());
      n_mixed = $urandom_range(8, 16);
      repeat (n_mixed) begin
        if ($urandom_range(0, 3) == 0) send_item(bcz_pkg::FUNC_LOAD, rand_pixel());
        else send_item(bcz_pkg::FUNC_EMIT, 16'($urandom));
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bilinear_center_zoom_unit verification clean");
    end else begin
      $display("bilinear_center_zoom_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== bilinear_center_zoom_unit.f =====
rtl/bcz_pkg.sv
rtl/bcz_ram.sv
rtl/bcz_coord.sv
rtl/bcz_blend.sv
rtl/bilinear_center_zoom_unit.sv
tb/tb_bilinear_center_zoom_unit.sv
